/* rtl/tet_pkg.sv */
// Shared types, character codes and run-building functions for the terminal
// escape and charset translator. Used by every module under rtl/.
package tet_pkg;

   // sizes
   localparam int MaxRun = 20;
   localparam int LenW   = 5;
   localparam int ChW    = 7;
   localparam int DataW  = 8;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 2;

   // register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] RegRawPass = 2'd0;
   localparam logic [CsrIdxW-1:0] RegNatSet  = 2'd1;
   localparam logic [CsrIdxW-1:0] RegEscXlat = 2'd2;

   // national letter sets
   localparam logic [1:0] NatAscii   = 2'd0;
   localparam logic [1:0] NatSwedish = 2'd2;

   // control codes on the 7-bit input
   localparam logic [ChW-1:0] CtlBel   = 7'h07;
   localparam logic [ChW-1:0] CtlBs    = 7'h08;
   localparam logic [ChW-1:0] CtlTab   = 7'h09;
   localparam logic [ChW-1:0] CtlLf    = 7'h0A;
   localparam logic [ChW-1:0] CtlFf    = 7'h0C;
   localparam logic [ChW-1:0] CtlCr    = 7'h0D;
   localparam logic [ChW-1:0] CtlEsc   = 7'h1B;
   localparam logic [ChW-1:0] CtlSpace = 7'h20;
   localparam logic [ChW-1:0] CtlDel   = 7'h7F;
   localparam logic [ChW-1:0] ArgBias  = 7'd31;

   // escape collector phases besides a pending command letter
   localparam logic [ChW-1:0] PhaseIdle = 7'h00;
   localparam logic [ChW-1:0] PhaseEsc  = CtlEsc;

   // argument counts
   localparam logic [1:0] NeedNone = 2'd0;
   localparam logic [1:0] NeedOne  = 2'd1;
   localparam logic [1:0] NeedTwo  = 2'd2;

   // command letters after escape
   localparam logic [ChW-1:0] CmdCup      = 7'h59;
   localparam logic [ChW-1:0] CmdAttr     = 7'h53;
   localparam logic [ChW-1:0] CmdSkipA    = 7'h2E;
   localparam logic [ChW-1:0] CmdSkipB    = 7'h2F;
   localparam logic [ChW-1:0] CmdRevOn    = 7'h27;
   localparam logic [ChW-1:0] CmdRevOff   = 7'h28;
   localparam logic [ChW-1:0] CmdBlinkOn  = 7'h29;
   localparam logic [ChW-1:0] CmdBlinkOff = 7'h2A;
   localparam logic [ChW-1:0] CmdUlineOn  = 7'h25;
   localparam logic [ChW-1:0] CmdUlineOff = 7'h26;
   localparam logic [ChW-1:0] CmdDimOn    = 7'h2C;
   localparam logic [ChW-1:0] CmdDimOff   = 7'h2B;
   localparam logic [ChW-1:0] CmdUp       = 7'h41;
   localparam logic [ChW-1:0] CmdDown     = 7'h42;
   localparam logic [ChW-1:0] CmdRight    = 7'h43;
   localparam logic [ChW-1:0] CmdLeft     = 7'h44;
   localparam logic [ChW-1:0] CmdHome     = 7'h48;
   localparam logic [ChW-1:0] CmdRevIdx   = 7'h49;
   localparam logic [ChW-1:0] CmdClrEos   = 7'h4A;
   localparam logic [ChW-1:0] CmdClrEol   = 7'h4B;
   localparam logic [ChW-1:0] CmdClearL   = 7'h4C;
   localparam logic [ChW-1:0] CmdClearM   = 7'h4D;
   localparam logic [ChW-1:0] CmdClearQ   = 7'h60;
   localparam logic [ChW-1:0] CmdGfxOn    = 7'h46;
   localparam logic [ChW-1:0] CmdGfxOff   = 7'h47;
   localparam logic [ChW-1:0] CmdInsLine  = 7'h54;
   localparam logic [ChW-1:0] CmdDelLine  = 7'h55;

   // output characters
   localparam logic [DataW-1:0] ChEsc   = 8'h1B;
   localparam logic [DataW-1:0] ChLbr   = 8'h5B;
   localparam logic [DataW-1:0] ChLpar  = 8'h28;
   localparam logic [DataW-1:0] ChSemi  = 8'h3B;
   localparam logic [DataW-1:0] ChMinus = 8'h2D;
   localparam logic [DataW-1:0] ChDig0  = 8'h30;
   localparam logic [DataW-1:0] ChLowM  = 8'h6D;
   localparam logic [DataW-1:0] ChUpB   = 8'h42;
   localparam logic [DataW-1:0] ChUpH   = 8'h48;
   localparam logic [DataW-1:0] ChUpJ   = 8'h4A;
   localparam logic [DataW-1:0] ChUpM   = 8'h4D;
   localparam logic [DataW-1:0] Utf8Lead = 8'hC0;
   localparam logic [DataW-1:0] Utf8Cont = 8'h80;

   // national code points and their letters (latin-1 values)
   localparam logic [9:0][ChW-1:0] NatCode = {7'h7E, 7'h5E, 7'h60, 7'h40, 7'h7D,
                                              7'h7C, 7'h7B, 7'h5D, 7'h5C, 7'h5B};
   localparam logic [5:0][DataW-1:0] NorLetter = {8'hE5, 8'hF8, 8'hE6,
                                                  8'hC5, 8'hD8, 8'hC6};
   localparam logic [9:0][DataW-1:0] SweLetter = {8'hFC, 8'hDC, 8'hE9, 8'hC9, 8'hE5,
                                                  8'hF6, 8'hE4, 8'hC5, 8'hD6, 8'hC4};

   typedef struct packed {
      logic       raw_pass;
      logic [1:0] national_set;
      logic       escape_translate;
   } cfg_type;

   // one run of output bytes, byte 0 goes out first
   typedef struct packed {
      logic [MaxRun-1:0][DataW-1:0] data;
      logic [LenW-1:0]              len;
   } run_type;

   // handoff from the decoder to the output stage
   typedef struct packed {
      logic    valid;
      run_type run;
   } load_type;

   function automatic run_type run_put(input run_type r, input logic [DataW-1:0] b);
      run_type o;
      o = r;
      if (r.len < LenW'(MaxRun)) begin
         o.data[r.len] = b;
         o.len         = r.len + 1'b1;
      end
      return o;
   endfunction

   function automatic logic [DataW-1:0] digit(input logic [3:0] n);
      return ChDig0 | {4'b0000, n};
   endfunction

   // ESC [ b
   function automatic run_type run_csi(input run_type r, input logic [DataW-1:0] b);
      run_type o;
      o = run_put(r, ChEsc);
      o = run_put(o, ChLbr);
      o = run_put(o, b);
      return o;
   endfunction

   // ESC [ d m
   function automatic run_type run_sgr1(input run_type r, input logic [3:0] d);
      run_type o;
      o = run_csi(r, digit(d));
      o = run_put(o, ChLowM);
      return o;
   endfunction

   // ESC [ d1 d2 m
   function automatic run_type run_sgr2(input run_type r, input logic [3:0] d1,
                                        input logic [3:0] d2);
      run_type o;
      o = run_csi(r, digit(d1));
      o = run_put(o, digit(d2));
      o = run_put(o, ChLowM);
      return o;
   endfunction

   // ESC [ H ESC [ 2 J
   function automatic run_type run_home_clear(input run_type r);
      run_type o;
      o = run_csi(r, ChUpH);
      o = run_csi(o, digit(4'd2));
      o = run_put(o, ChUpJ);
      return o;
   endfunction

   // argument minus bias in signed decimal, magnitude stays below 100
   function automatic run_type run_dec(input run_type r, input logic [ChW-1:0] a);
      run_type     o;
      logic        neg;
      logic [6:0]  mag;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [3:0]  ones;
      neg  = a < ArgBias;
      mag  = neg ? (ArgBias - a) : (a - ArgBias);
      // divide by ten through the reciprocal 205/2048
      prod = 15'(mag) * 15'd205;
      tens = prod[14:11];
      ones = 4'(mag - 7'({3'b000, tens} * 7'd10));
      o = r;
      if (neg) o = run_put(o, ChMinus);
      if (mag >= 7'd10) o = run_put(o, digit(tens));
      o = run_put(o, digit(ones));
      return o;
   endfunction

   // latin-1 letter for a national code, zero when none applies
   function automatic logic [DataW-1:0] nat_letter(input logic [1:0] ns,
                                                   input logic [ChW-1:0] ch);
      logic [DataW-1:0] u;
      u = '0;
      if (ns == NatSwedish) begin
         for (int i = 0; i < 10; i++)
            if (NatCode[i] == ch) u = SweLetter[i];
      end else if (ns != NatAscii) begin
         for (int i = 0; i < 6; i++)
            if (NatCode[i] == ch) u = NorLetter[i];
      end
      return u;
   endfunction

   // ordinary character outside an escape sequence
   function automatic run_type plain_run(input logic [ChW-1:0] ch, input cfg_type cfg);
      run_type          o;
      logic [DataW-1:0] u;
      o = '0;
      u = nat_letter(cfg.national_set, ch);
      if (ch < CtlSpace) begin
         if (ch == CtlCr || ch == CtlLf || ch == CtlBel || ch == CtlBs || ch == CtlTab)
            o = run_put(o, {1'b0, ch});
         else if (ch == CtlFf && cfg.escape_translate)
            o = run_home_clear(o);
      end else if (ch != CtlDel) begin
         if (u != '0) begin
            o = run_put(o, Utf8Lead | {6'b000000, u[7:6]});
            o = run_put(o, Utf8Cont | {2'b00, u[5:0]});
         end else begin
            o = run_put(o, {1'b0, ch});
         end
      end
      return o;
   endfunction

   function automatic logic [1:0] needed_args(input logic [ChW-1:0] cmd);
      logic [1:0] n;
      unique case (cmd)
         CmdCup:                     n = NeedTwo;
         CmdAttr, CmdSkipA, CmdSkipB: n = NeedOne;
         default:                    n = NeedNone;
      endcase
      return n;
   endfunction

   // byte run for a completed escape command
   function automatic run_type cmd_run(input logic [ChW-1:0] cmd, input logic [ChW-1:0] a0,
                                       input logic [ChW-1:0] a1);
      run_type o;
      o = '0;
      unique case (cmd)
         CmdCup: begin
            o = run_put(o, ChEsc);
            o = run_put(o, ChLbr);
            o = run_dec(o, a0);
            o = run_put(o, ChSemi);
            o = run_dec(o, a1);
            o = run_put(o, ChUpH);
         end
         CmdAttr: begin
            o = run_sgr1(o, 4'd0);
            if (a0[0]) o = run_sgr1(o, 4'd7);
            if (a0[1]) o = run_sgr1(o, 4'd5);
            if (a0[2]) o = run_sgr1(o, 4'd4);
            if (a0[3]) o = run_sgr1(o, 4'd2);
         end
         CmdRevOn:    o = run_sgr1(o, 4'd7);
         CmdRevOff:   o = run_sgr2(o, 4'd2, 4'd7);
         CmdBlinkOn:  o = run_sgr1(o, 4'd5);
         CmdBlinkOff: o = run_sgr2(o, 4'd2, 4'd5);
         CmdUlineOn:  o = run_sgr1(o, 4'd4);
         CmdUlineOff: o = run_sgr2(o, 4'd2, 4'd4);
         CmdDimOn:    o = run_sgr1(o, 4'd2);
         CmdDimOff:   o = run_sgr2(o, 4'd2, 4'd2);
         CmdUp, CmdDown, CmdRight, CmdLeft, CmdHome, CmdClrEos, CmdClrEol:
            o = run_csi(o, {1'b0, cmd});
         CmdInsLine:  o = run_csi(o, {1'b0, CmdClearL});
         CmdDelLine:  o = run_csi(o, {1'b0, CmdClearM});
         CmdRevIdx: begin
            o = run_put(o, ChEsc);
            o = run_put(o, ChUpM);
         end
         CmdClearL, CmdClearM, CmdClearQ: o = run_home_clear(o);
         CmdGfxOn: begin
            o = run_put(o, ChEsc);
            o = run_put(o, ChLpar);
            o = run_put(o, digit(4'd0));
         end
         CmdGfxOff: begin
            o = run_put(o, ChEsc);
            o = run_put(o, ChLpar);
            o = run_put(o, ChUpB);
         end
         default: o = '0;
      endcase
      return o;
   endfunction

endpackage

/* rtl/tet_csr.sv */
// Configuration register file of the translator: raw pass, national set and
// escape translation. Depends on tet_pkg.
module tet_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tet_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [tet_pkg::CsrDataW-1:0]    csr_data,
   output tet_pkg::cfg_type                cfg
);

   tet_pkg::cfg_type cfg_ff;
   tet_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tet_pkg::RegRawPass: cfg_in.raw_pass         = csr_data[0];
            tet_pkg::RegNatSet:  cfg_in.national_set     = csr_data;
            tet_pkg::RegEscXlat: cfg_in.escape_translate = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/tet_decode.sv */
// Request register, escape collector state and run builder of the translator.
// Depends on tet_pkg; feeds tet_emit through a load_type handoff.
module tet_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tet_pkg::DataW-1:0]      req_tdata,   // [7:0] char_in
   input  tet_pkg::cfg_type               cfg,
   input  logic                           load_ok,
   output tet_pkg::load_type              load
);

   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic [tet_pkg::DataW-1:0]    in_char_ff;
   logic [tet_pkg::ChW-1:0]      phase_ff;
   logic [tet_pkg::ChW-1:0]      phase_in;
   logic                         argc_ff;
   logic                         argc_in;
   logic [tet_pkg::ChW-1:0]      first_ff;
   logic [tet_pkg::ChW-1:0]      first_in;
   logic [tet_pkg::ChW-1:0]      ch;
   logic [1:0]                   need;
   tet_pkg::run_type             run;
   logic                         advance;

   assign ch   = in_char_ff[tet_pkg::ChW-1:0];
   assign need = tet_pkg::needed_args(phase_ff);

   // escape collector and run selection
   always_comb begin
      phase_in = phase_ff;
      argc_in  = argc_ff;
      first_in = first_ff;
      run      = '0;
      if (cfg.raw_pass) begin
         run = tet_pkg::run_put('0, {1'b0, ch});
      end else if (!cfg.escape_translate) begin
         run = tet_pkg::plain_run(ch, cfg);
      end else if (phase_ff == tet_pkg::PhaseEsc) begin
         if (tet_pkg::needed_args(ch) != tet_pkg::NeedNone) begin
            phase_in = ch;
            argc_in  = 1'b0;
         end else begin
            phase_in = tet_pkg::PhaseIdle;
            run      = tet_pkg::cmd_run(ch, '0, '0);
         end
      end else if (phase_ff != tet_pkg::PhaseIdle) begin
         if (!argc_ff && need == tet_pkg::NeedTwo) begin
            first_in = ch;
            argc_in  = 1'b1;
         end else begin
            run      = tet_pkg::cmd_run(phase_ff,
                                        (need == tet_pkg::NeedTwo) ? first_ff : ch, ch);
            phase_in = tet_pkg::PhaseIdle;
            argc_in  = 1'b0;
         end
      end else if (ch == tet_pkg::CtlEsc) begin
         phase_in = tet_pkg::PhaseEsc;
      end else begin
         run = tet_pkg::plain_run(ch, cfg);
      end
   end

   // an empty run retires at once, otherwise wait for the output stage
   assign advance    = in_valid_ff && (run.len == '0 || load_ok);
   assign req_tready = !in_valid_ff || advance;
   assign load.valid = advance && (run.len != '0);
   assign load.run   = run;

   // request register valid
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= tet_pkg::PhaseIdle;
         argc_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            argc_ff  <= argc_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_char_ff <= req_tdata;
      if (advance)                  first_ff   <= first_in;
   end

endmodule

/* rtl/tet_emit.sv */
// Output stage of the translator: holds one byte run and shifts it out one
// byte per response. Depends on tet_pkg.
module tet_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  tet_pkg::load_type            load,
   output logic                         load_ok,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tet_pkg::DataW-1:0]    rsp_tdata,   // [7:0] out_byte
   output logic                         rsp_tlast    // last_byte
);

   logic [tet_pkg::MaxRun-1:0][tet_pkg::DataW-1:0] data_ff;
   logic [tet_pkg::MaxRun-1:0][tet_pkg::DataW-1:0] data_in;
   logic [tet_pkg::LenW-1:0]                       cnt_ff;
   logic [tet_pkg::LenW-1:0]                       cnt_in;
   logic                                           take;

   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = cnt_ff == tet_pkg::LenW'(1);
   assign take       = rsp_tvalid && rsp_tready;
   // free now, or the final byte leaves this cycle
   assign load_ok    = !rsp_tvalid || (rsp_tlast && rsp_tready);

   // load a new run or shift the current one
   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (load.valid) begin
         data_in = load.run.data;
         cnt_in  = load.run.len;
      end else if (take) begin
         data_in = {{tet_pkg::DataW{1'b0}}, data_ff[tet_pkg::MaxRun-1:1]};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* rtl/terminal_escape_charset_translator_top.sv */
// Terminal output translator. Each request carries one program byte; its top
// bit is dropped and it becomes a run of zero to twenty host bytes, the last
// one flagged by rsp_tlast. The first byte passes the request register and
// then the output run register. Requests yielding no byte stream at one per
// cycle, those yielding one byte while rsp_tready is high. A run is loaded
// only as the last byte of the one before leaves, and the run register sends
// one byte per cycle while rsp_tready is high. Configuration writes are taken
// in every cycle. Depends on tet_pkg, tet_csr, tet_decode and tet_emit.
module terminal_escape_charset_translator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tet_pkg::DataW-1:0]       req_tdata,   // [7:0] char_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tet_pkg::DataW-1:0]       rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast,   // last_byte
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tet_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [tet_pkg::CsrDataW-1:0]    csr_data
);

   tet_pkg::cfg_type  cfg;
   tet_pkg::load_type load;
   logic              load_ok;

   // configuration registers
   tet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // request register and run builder
   tet_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .load_ok    (load_ok),
      .load       (load)
   );

   // run register and response channel
   tet_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* rtl/tet_checker.sv */
// Port-level checks for the translator and the bind that attaches them to
// the top level. Depends on tet_pkg.
module tet_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tet_pkg::DataW-1:0]       rsp_tdata,
   input  logic                            rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // bytes of one run follow without a gap
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a byte run");

   // a utf-8 lead byte is never the end of a run
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:6] == 2'b11 |-> !rsp_tlast)
      else $error("utf-8 lead byte ends a run");

   // a utf-8 continuation byte always ends its run
   a_cont_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7:6] == 2'b10 |-> rsp_tlast)
      else $error("utf-8 continuation byte not last");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind terminal_escape_charset_translator_top tet_checker u_checker (.*);
